>>> sv/lpsm_pkg.sv
// ----------------------------------------------------------------------------
// lpsm_pkg
// Shared constants and the arc-tangent table for the squat metrics block.
// ----------------------------------------------------------------------------
package lpsm_pkg;

   // Configuration register indexes.
   localparam logic [1:0] CSR_SCORE_THRESHOLD  = 2'd0;
   localparam logic [1:0] CSR_STANDING_LIMIT   = 2'd1;
   localparam logic [1:0] CSR_SEMI_SQUAT_LIMIT = 2'd2;

   // Squat class codes.
   localparam logic [1:0] CLASS_STANDING = 2'd0;
   localparam logic [1:0] CLASS_SEMI     = 2'd1;
   localparam logic [1:0] CLASS_DEEP     = 2'd2;

   // Rotation engine constants.
   localparam int CORDIC_STEPS  = 23;
   localparam int PRE_SCALE     = 24;
   localparam int DEG_UNIT_BITS = 16;
   localparam int ZW            = 26;
   localparam int STEP_W        = 5;

   // Fixed point constants.
   localparam int Q12_ONE       = 4096;
   localparam int COMP_SAT_Q    = 12288;
   localparam int SYM_SCALE     = 3200;
   localparam int COMP_W        = 14;
   localparam int SYM_W         = 12;

   // Arc-tangent of 2^-i in units of 2^-16 degree.
   function automatic logic [ZW-1:0] atan_step(input logic [STEP_W-1:0] idx);
      logic [ZW-1:0] val;
      case (idx)
         5'd0:    val = ZW'(2949120);
         5'd1:    val = ZW'(1740967);
         5'd2:    val = ZW'(919879);
         5'd3:    val = ZW'(466945);
         5'd4:    val = ZW'(234379);
         5'd5:    val = ZW'(117304);
         5'd6:    val = ZW'(58666);
         5'd7:    val = ZW'(29335);
         5'd8:    val = ZW'(14668);
         5'd9:    val = ZW'(7334);
         5'd10:   val = ZW'(3667);
         5'd11:   val = ZW'(1833);
         5'd12:   val = ZW'(917);
         5'd13:   val = ZW'(458);
         5'd14:   val = ZW'(229);
         5'd15:   val = ZW'(115);
         5'd16:   val = ZW'(57);
         5'd17:   val = ZW'(29);
         5'd18:   val = ZW'(14);
         5'd19:   val = ZW'(7);
         5'd20:   val = ZW'(4);
         5'd21:   val = ZW'(2);
         5'd22:   val = ZW'(1);
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

>>> sv/leg_pose_squat_metrics.sv
// ----------------------------------------------------------------------------
// leg_pose_squat_metrics
// Knee angles, leg compression, squat class and symmetry from two legs.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Transfer carries
// req_      in         one leg: tdata landmarks and scores, tlast set on right leg
// rsp_      out        one frame result after each right leg
// csr_      in         register writes, no read-back
//
// A left leg uses the shared multiplier for the four products of dot and
// cross, then 23 steps of the rotation engine, with the compression
// division running alongside it.  A right leg then also runs the
// symmetry quotient through the bit-serial divider, whose length is DIV_DW =
// max(COORD_BITS, 8 + ANGLE_FRAC_BITS) + 12.
// Reset is synchronous and active high; it clears the held left leg, both
// standing references and the registers to their documented defaults.
// A finished result waits in the output register while the next leg is
// accepted; only a second result waiting on a stalled output holds the block.
//
module leg_pose_squat_metrics
   import lpsm_pkg::*;
#(
   parameter int COORD_BITS      = 12,
   parameter int ANGLE_FRAC_BITS = 4
) (
   input  logic        clock,
   input  logic        reset,
   // tdata: hip_x, hip_y, knee_x, knee_y, ankle_x, ankle_y, hip_score,
   //        knee_score, ankle_score (from the lowest bit up)
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [((6*COORD_BITS+24+7)/8)*8-1:0] req_tdata,
   input  logic        req_tlast,
   // tdata: left_angle, left_valid, right_angle, right_valid,
   //        left_compression, right_compression, squat_class, symmetry,
   //        symmetry_valid (from the lowest bit up)
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [((2*(8+ANGLE_FRAC_BITS)+45+7)/8)*8-1:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [12:0] csr_wdata
);

   localparam int CB      = COORD_BITS;
   localparam int DIFF_W  = CB + 1;
   localparam int ACC_W   = 2 * DIFF_W;
   localparam int AW      = 8 + ANGLE_FRAC_BITS;
   localparam int CDW     = CB + 12;
   localparam int SDW     = AW + 12;
   localparam int DIV_DW  = (CDW > SDW) ? CDW : SDW;
   localparam int DIV_VW  = (CB > AW + 1) ? CB : AW + 1;
   localparam int RSP_W   = ((2 * AW + 45 + 7) / 8) * 8;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MUL  = 3'd1;
   localparam logic [2:0] S_CST  = 3'd2;
   localparam logic [2:0] S_CORD = 3'd3;
   localparam logic [2:0] S_FIN  = 3'd4;
   localparam logic [2:0] S_MIX  = 3'd5;
   localparam logic [2:0] S_SYM  = 3'd6;
   localparam logic [2:0] S_OUT  = 3'd7;

   // Registers.
   logic [2:0]                state_ff, state_in;
   logic [1:0]                cnt_ff, cnt_in;
   logic [7:0]                thr_ff, thr_in;
   logic [12:0]               stand_ff, stand_in, semi_ff, semi_in;
   logic [CB-1:0]             lref_ff, lref_in, rref_ff, rref_in;
   logic                      side_ff, side_in, valid_ff, valid_in;
   logic                      degen_ff, degen_in, div_run_ff, div_run_in;
   logic signed [DIFF_W-1:0]  bax_ff, bax_in, bay_ff, bay_in;
   logic signed [DIFF_W-1:0]  bcx_ff, bcx_in, bcy_ff, bcy_in;
   logic signed [ACC_W-1:0]   dot_ff, dot_in, cr_ff, cr_in;
   logic [AW-1:0]             angle_ff, angle_in;
   logic signed [COMP_W-1:0]  comp_ff, comp_in;
   logic [AW-1:0]             hangle_ff, hangle_in;
   logic                      hvalid_ff, hvalid_in;
   logic signed [COMP_W-1:0]  hcomp_ff, hcomp_in;
   logic [1:0]                class_ff, class_in;
   logic                      sv_ff, sv_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]          rsp_data_ff, rsp_data_in;

   // Combinational helpers.
   logic                      accept;
   logic [CB-1:0]             hip_x, hip_y, knee_x, knee_y, ankle_x, ankle_y;
   logic [7:0]                hip_score, knee_score, ankle_score;
   logic [CB-1:0]             len, ref_cur;
   logic                      leg_ok;
   logic signed [DIFF_W-1:0]  op_a, op_b;
   logic signed [ACC_W-1:0]   prod;
   logic                      cord_start, cord_busy;
   logic [AW-1:0]             cord_angle;
   logic                      div_start, div_busy;
   logic [DIV_DW-1:0]         div_dividend, quotient;
   logic [DIV_VW-1:0]         div_divisor;
   logic [AW-1:0]             diff;
   logic [AW:0]               angle_sum;
   logic signed [15:0]        comp_sum;
   logic [SYM_W-1:0]          sym;

   assign hip_x       = req_tdata[CB-1:0];
   assign hip_y       = req_tdata[2*CB-1:CB];
   assign knee_x      = req_tdata[3*CB-1:2*CB];
   assign knee_y      = req_tdata[4*CB-1:3*CB];
   assign ankle_x     = req_tdata[5*CB-1:4*CB];
   assign ankle_y     = req_tdata[6*CB-1:5*CB];
   assign hip_score   = req_tdata[6*CB+7:6*CB];
   assign knee_score  = req_tdata[6*CB+15:6*CB+8];
   assign ankle_score = req_tdata[6*CB+23:6*CB+16];

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      len     = (ankle_y >= hip_y) ? ankle_y - hip_y : hip_y - ankle_y;
      ref_cur = req_tlast ? rref_ff : lref_ff;
      leg_ok  = (hip_score > thr_ff) && (knee_score > thr_ff) && (ankle_score > thr_ff);
   end

   // One shared multiplier walks the four products of dot and cross.
   always_comb begin
      case (cnt_ff)
         2'd0:    begin op_a = bax_ff; op_b = bcx_ff; end
         2'd1:    begin op_a = bay_ff; op_b = bcy_ff; end
         2'd2:    begin op_a = bax_ff; op_b = bcy_ff; end
         default: begin op_a = bay_ff; op_b = bcx_ff; end
      endcase
      prod = ACC_W'(op_a) * ACC_W'(op_b);
   end

   // The divider serves the compression ratio on acceptance and the
   // symmetry ratio once both legs are known.
   always_comb begin
      diff      = (hangle_ff >= angle_ff) ? hangle_ff - angle_ff : angle_ff - hangle_ff;
      angle_sum = {1'b0, hangle_ff} + {1'b0, angle_ff};
      if (state_ff == S_IDLE) begin
         div_start    = accept && leg_ok && (len != '0);
         div_dividend = DIV_DW'({len, 12'b0});
         div_divisor  = DIV_VW'((ref_cur == '0) ? len : ref_cur);
      end else begin
         div_start    = (state_ff == S_MIX) && side_ff &&
                        (hangle_ff != '0) && (angle_ff != '0);
         div_dividend = DIV_DW'(diff) * DIV_DW'(SYM_SCALE);
         div_divisor  = DIV_VW'(angle_sum);
      end
   end

   assign cord_start = (state_ff == S_CST) && valid_ff && !degen_ff;

   lpsm_divider #(
      .DW (DIV_DW),
      .VW (DIV_VW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .quotient (quotient)
   );

   lpsm_cordic #(
      .IN_W            (ACC_W),
      .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
   ) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .start     (cord_start),
      .dot       (dot_ff),
      .cross_val (cr_ff),
      .busy      (cord_busy),
      .angle     (cord_angle)
   );

   assign comp_sum = 16'(hcomp_ff) + 16'(comp_ff);
   assign sym      = sv_ff ? quotient[SYM_W-1:0] : '0;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      thr_in       = thr_ff;
      stand_in     = stand_ff;
      semi_in      = semi_ff;
      lref_in      = lref_ff;
      rref_in      = rref_ff;
      side_in      = side_ff;
      valid_in     = valid_ff;
      degen_in     = degen_ff;
      div_run_in   = div_run_ff;
      bax_in       = bax_ff;
      bay_in       = bay_ff;
      bcx_in       = bcx_ff;
      bcy_in       = bcy_ff;
      dot_in       = dot_ff;
      cr_in        = cr_ff;
      angle_in     = angle_ff;
      comp_in      = comp_ff;
      hangle_in    = hangle_ff;
      hvalid_in    = hvalid_ff;
      hcomp_in     = hcomp_ff;
      class_in     = class_ff;
      sv_in        = sv_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (csr_we) begin
         case (csr_addr)
            CSR_SCORE_THRESHOLD:  thr_in   = csr_wdata[7:0];
            CSR_STANDING_LIMIT:   stand_in = csr_wdata;
            CSR_SEMI_SQUAT_LIMIT: semi_in  = csr_wdata;
            default:              ;
         endcase
      end

      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               side_in    = req_tlast;
               valid_in   = leg_ok;
               div_run_in = div_start;
               bax_in     = $signed({1'b0, hip_x}) - $signed({1'b0, knee_x});
               bay_in     = $signed({1'b0, hip_y}) - $signed({1'b0, knee_y});
               bcx_in     = $signed({1'b0, ankle_x}) - $signed({1'b0, knee_x});
               bcy_in     = $signed({1'b0, ankle_y}) - $signed({1'b0, knee_y});
               degen_in   = ((hip_x == knee_x) && (hip_y == knee_y)) ||
                            ((ankle_x == knee_x) && (ankle_y == knee_y));
               // The first standing height seen on a side becomes its reference.
               if (leg_ok && (len != '0) && (ref_cur == '0)) begin
                  if (req_tlast) begin
                     rref_in = len;
                  end else begin
                     lref_in = len;
                  end
               end
               cnt_in   = '0;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            case (cnt_ff)
               2'd0:    dot_in = prod;
               2'd1:    dot_in = dot_ff + prod;
               2'd2:    cr_in  = prod;
               default: cr_in  = cr_ff - prod;
            endcase
            cnt_in = cnt_ff + 2'd1;
            if (cnt_ff == 2'd3) begin
               state_in = S_CST;
            end
         end
         S_CST: begin
            state_in = S_CORD;
         end
         S_CORD: begin
            if (!cord_busy && !div_busy) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            angle_in = (valid_ff && !degen_ff) ? cord_angle : '0;
            if (!div_run_ff) begin
               comp_in = '0;
            end else if (quotient > DIV_DW'(COMP_SAT_Q)) begin
               comp_in = COMP_W'(-8192);
            end else begin
               comp_in = COMP_W'(Q12_ONE) - $signed(quotient[COMP_W-1:0]);
            end
            state_in = S_MIX;
         end
         S_MIX: begin
            if (!side_ff) begin
               // A left leg is held, replacing any earlier one.
               hangle_in = angle_ff;
               hvalid_in = valid_ff;
               hcomp_in  = comp_ff;
               state_in  = S_IDLE;
            end else begin
               if (comp_sum < $signed({2'b00, stand_ff, 1'b0})) begin
                  class_in = CLASS_STANDING;
               end else if (comp_sum < $signed({2'b00, semi_ff, 1'b0})) begin
                  class_in = CLASS_SEMI;
               end else begin
                  class_in = CLASS_DEEP;
               end
               sv_in    = (hangle_ff != '0) && (angle_ff != '0);
               state_in = S_SYM;
            end
         end
         S_SYM: begin
            if (!div_busy) begin
               state_in = S_OUT;
            end
         end
         default: begin
            // Load the output register as soon as it is free.
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               rsp_data_in[AW-1:0]             = hangle_ff;
               rsp_data_in[AW]                 = hvalid_ff;
               rsp_data_in[2*AW:AW+1]          = angle_ff;
               rsp_data_in[2*AW+1]             = valid_ff;
               rsp_data_in[2*AW+15:2*AW+2]     = hcomp_ff;
               rsp_data_in[2*AW+29:2*AW+16]    = comp_ff;
               rsp_data_in[2*AW+31:2*AW+30]    = class_ff;
               rsp_data_in[2*AW+43:2*AW+32]    = sym;
               rsp_data_in[2*AW+44]            = sv_ff;
               hangle_in = '0;
               hvalid_in = 1'b0;
               hcomp_in  = '0;
               state_in  = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         thr_ff       <= 8'd128;
         stand_ff     <= 13'd410;
         semi_ff      <= 13'd1024;
         lref_ff      <= '0;
         rref_ff      <= '0;
         hangle_ff    <= '0;
         hvalid_ff    <= 1'b0;
         hcomp_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         thr_ff       <= thr_in;
         stand_ff     <= stand_in;
         semi_ff      <= semi_in;
         lref_ff      <= lref_in;
         rref_ff      <= rref_in;
         hangle_ff    <= hangle_in;
         hvalid_ff    <= hvalid_in;
         hcomp_ff     <= hcomp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cnt_ff      <= cnt_in;
      side_ff     <= side_in;
      valid_ff    <= valid_in;
      degen_ff    <= degen_in;
      div_run_ff  <= div_run_in;
      bax_ff      <= bax_in;
      bay_ff      <= bay_in;
      bcx_ff      <= bcx_in;
      bcy_ff      <= bcy_in;
      dot_ff      <= dot_in;
      cr_ff       <= cr_in;
      angle_ff    <= angle_in;
      comp_ff     <= comp_in;
      class_ff    <= class_in;
      sv_ff       <= sv_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

>>> sv/lpsm_divider.sv
// ----------------------------------------------------------------------------
// lpsm_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lpsm_divider
   import lpsm_pkg::*;
#(
   parameter int DW = 24,
   parameter int VW = 13
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [VW-1:0] divisor,
   output logic          busy,
   output logic [DW-1:0] quotient
);

   localparam int CW = (DW > 1) ? $clog2(DW) : 1;

   logic          busy_ff, busy_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [DW-1:0] quo_ff, quo_in;
   logic [VW-1:0] rem_ff, rem_in;
   logic [VW-1:0] dsr_ff, dsr_in;
   logic [VW:0]   trial;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      trial   = {rem_ff, quo_ff[DW-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(DW - 1);
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         // Shift in the next dividend bit and subtract when it fits.
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = VW'(trial - {1'b0, dsr_ff});
            quo_in = {quo_ff[DW-2:0], 1'b1};
         end else begin
            rem_in = trial[VW-1:0];
            quo_in = {quo_ff[DW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

>>> sv/lpsm_cordic.sv
// ----------------------------------------------------------------------------
// lpsm_cordic
// Vectoring rotation engine giving atan2(|cross|, dot), one step per cycle.
// ----------------------------------------------------------------------------
module lpsm_cordic
   import lpsm_pkg::*;
#(
   parameter int IN_W            = 26,
   parameter int ANGLE_FRAC_BITS = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [IN_W-1:0]  dot,
   input  logic signed [IN_W-1:0]  cross_val,
   output logic                    busy,
   output logic [7+ANGLE_FRAC_BITS:0] angle
);

   localparam int W  = IN_W + PRE_SCALE + 2;
   localparam int AW = 8 + ANGLE_FRAC_BITS;
   localparam int SH = DEG_UNIT_BITS - ANGLE_FRAC_BITS;
   localparam logic [ZW-1:0] HALF   = ZW'(1) << (SH - 1);
   localparam logic [ZW-1:0] MAX_A  = ZW'(180) << ANGLE_FRAC_BITS;
   localparam logic [ZW-1:0] RIGHT  = ZW'(90) << DEG_UNIT_BITS;

   logic                    busy_ff, busy_in;
   logic [STEP_W-1:0]       step_ff, step_in;
   logic signed [W-1:0]     x_ff, x_in, y_ff, y_in;
   logic signed [ZW-1:0]    z_ff, z_in;
   logic signed [IN_W-1:0]  cross_abs;
   logic signed [W-1:0]     dot_w, cross_w, dx, dy;
   logic [ZW-1:0]           z_pos, rnd;

   always_comb begin
      busy_in   = busy_ff;
      step_in   = step_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      z_in      = z_ff;
      cross_abs = (cross_val < 0) ? -cross_val : cross_val;
      dot_w     = W'(dot) <<< PRE_SCALE;
      cross_w   = W'(cross_abs) <<< PRE_SCALE;
      dx        = y_ff >>> step_ff;
      dy        = x_ff >>> step_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         // An obtuse angle is first turned by a right angle.
         if (dot < 0) begin
            x_in = cross_w;
            y_in = -dot_w;
            z_in = $signed(RIGHT);
         end else begin
            x_in = dot_w;
            y_in = cross_w;
            z_in = '0;
         end
      end else if (busy_ff) begin
         if (y_ff > 0) begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            z_in = z_ff + $signed(atan_step(step_ff));
         end else begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            z_in = z_ff - $signed(atan_step(step_ff));
         end
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(CORDIC_STEPS - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      step_ff <= step_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
   end

   // Clamp at zero, round half up to the output unit, clamp at 180 degrees.
   always_comb begin
      z_pos = (z_ff < 0) ? '0 : ZW'(z_ff);
      rnd   = (z_pos + HALF) >> SH;
      angle = (rnd > MAX_A) ? MAX_A[AW-1:0] : rnd[AW-1:0];
   end

   assign busy = busy_ff;

endmodule

>>> sv/lpsm_checker.sv
// ----------------------------------------------------------------------------
// lpsm_checker
// Port-level checks on the squat metrics block, bound to its top level.
// ----------------------------------------------------------------------------
module lpsm_checker
   import lpsm_pkg::*;
#(
   parameter int COORD_BITS      = 12,
   parameter int ANGLE_FRAC_BITS = 4
) (
   input logic clock,
   input logic reset,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic [((2*(8+ANGLE_FRAC_BITS)+45+7)/8)*8-1:0] rsp_tdata
);

   localparam int AW = 8 + ANGLE_FRAC_BITS;
   localparam logic [AW-1:0] MAX_A = AW'(180 << ANGLE_FRAC_BITS);

   logic [AW-1:0] l_angle, r_angle;
   logic          l_valid, s_valid;
   logic [13:0]   l_comp;
   logic [1:0]    s_class;

   assign l_angle = rsp_tdata[AW-1:0];
   assign l_valid = rsp_tdata[AW];
   assign r_angle = rsp_tdata[2*AW:AW+1];
   assign l_comp  = rsp_tdata[2*AW+15:2*AW+2];
   assign s_class = rsp_tdata[2*AW+31:2*AW+30];
   assign s_valid = rsp_tdata[2*AW+44];

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   a_class_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> s_class == CLASS_STANDING || s_class == CLASS_SEMI ||
                     s_class == CLASS_DEEP)
      else $error("squat class out of range");

   a_sym_angles: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && s_valid |-> l_angle != '0 && r_angle != '0)
      else $error("symmetry valid with a zero angle");

   a_left_invalid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !l_valid |-> l_angle == '0 && l_comp == '0 &&
                                 r_angle <= MAX_A)
      else $error("invalid left leg carries values");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result offered after reset");

endmodule

bind leg_pose_squat_metrics lpsm_checker #(
   .COORD_BITS      (COORD_BITS),
   .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
) u_lpsm_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

>>> dv/lpsm_checker.sv
// ----------------------------------------------------------------------------
// lpsm_tb_checker
// Watches the leg, result and register ports of the squat metrics block,
// predicts every frame result and compares it field by field.
// ----------------------------------------------------------------------------
module lpsm_tb_checker
   import lpsm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [95:0] req_tdata,
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [71:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [12:0] csr_wdata,
   output int          mismatches,
   output int          frames_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic        sym_valid;
      logic [11:0] symmetry;
      logic [1:0]  squat_class;
      logic [13:0] right_comp;
      logic [13:0] left_comp;
      logic        right_valid;
      logic [11:0] right_angle;
      logic        left_valid;
      logic [11:0] left_angle;
   } frame_type;

   frame_type   frame_queue[$];
   logic [7:0]  threshold;
   logic [12:0] stand_lim;
   logic [12:0] semi_lim;
   longint      left_angle_hold;
   logic        left_valid_hold;
   longint      left_comp_hold;
   longint      left_ref;
   longint      right_ref;

   assign frames_pending = frame_queue.size();

   // Knee angle by the rotation engine in 2^-16 degree, rounded to 1/16 degree.
   function automatic longint leg_angle(longint hx, longint hy, longint kx, longint ky,
                                        longint ax, longint ay);
      longint ux, uy, vx, vy, dot, crs, x, y, z, t, dx, dy, res;
      ux = hx - kx; uy = hy - ky;
      vx = ax - kx; vy = ay - ky;
      if ((ux == 0 && uy == 0) || (vx == 0 && vy == 0)) return 0;
      dot = ux * vx + uy * vy;
      crs = ux * vy - uy * vx;
      if (crs < 0) crs = -crs;
      x = dot <<< PRE_SCALE;
      y = crs <<< PRE_SCALE;
      z = 0;
      if (x < 0) begin
         t = x; x = y; y = -t;
         z = 64'sd90 <<< DEG_UNIT_BITS;
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y > 0) begin
            x += dx; y -= dy; z += longint'(atan_step(i[4:0]));
         end else begin
            x -= dx; y += dy; z -= longint'(atan_step(i[4:0]));
         end
      end
      if (z < 0) z = 0;
      res = (z + 2048) >>> 12;
      if (res > 2880) res = 2880;
      return res;
   endfunction

   task automatic take_leg(input logic side, input logic [95:0] d);
      longint    hx, hy, kx, ky, ax, ay, ang, len, comp, q, sum, diff;
      logic      ok;
      frame_type f;
      hx = d[11:0];  hy = d[23:12]; kx = d[35:24];
      ky = d[47:36]; ax = d[59:48]; ay = d[71:60];
      ok = d[79:72] > threshold && d[87:80] > threshold && d[95:88] > threshold;
      ang = 0; comp = 0; len = 0; q = 0;
      if (ok) begin
         ang = leg_angle(hx, hy, kx, ky, ax, ay);
         len = (ay >= hy) ? ay - hy : hy - ay;
         if (side) begin
            if (right_ref == 0 && len > 0) right_ref = len;
            if (right_ref > 0 && len > 0) q = (len * Q12_ONE) / right_ref;
         end else begin
            if (left_ref == 0 && len > 0) left_ref = len;
            if (left_ref > 0 && len > 0) q = (len * Q12_ONE) / left_ref;
         end
         if (len > 0) comp = (q > COMP_SAT_Q) ? -8192 : Q12_ONE - q;
      end
      if (!side) begin
         left_angle_hold = ang; left_valid_hold = ok; left_comp_hold = comp;
         return;
      end
      sum = left_comp_hold + comp;
      if (sum < 2 * longint'(stand_lim)) f.squat_class = CLASS_STANDING;
      else if (sum < 2 * longint'(semi_lim)) f.squat_class = CLASS_SEMI;
      else f.squat_class = CLASS_DEEP;
      f.sym_valid   = left_angle_hold > 0 && ang > 0;
      f.symmetry    = '0;
      if (f.sym_valid) begin
         diff = (left_angle_hold >= ang) ? left_angle_hold - ang : ang - left_angle_hold;
         f.symmetry = 12'((diff * SYM_SCALE) / (left_angle_hold + ang));
      end
      f.left_angle  = 12'(left_angle_hold);
      f.left_valid  = left_valid_hold;
      f.right_angle = 12'(ang);
      f.right_valid = ok;
      f.left_comp   = 14'(left_comp_hold);
      f.right_comp  = 14'(comp);
      frame_queue.push_back(f);
      left_angle_hold = 0; left_valid_hold = 0; left_comp_hold = 0;
   endtask

   task automatic note_mismatch(input string what, input longint exp_v, input longint got_v);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, what, exp_v, got_v);
   endtask

   always @(posedge clock) begin
      frame_type e, g;
      if (reset) begin
         threshold = 8'd128; stand_lim = 13'd410; semi_lim = 13'd1024;
         left_angle_hold = 0; left_valid_hold = 0; left_comp_hold = 0;
         left_ref = 0; right_ref = 0;
         frame_queue.delete();
      end else begin
         if (csr_we) begin
            case (csr_addr)
               CSR_SCORE_THRESHOLD:  threshold = csr_wdata[7:0];
               CSR_STANDING_LIMIT:   stand_lim = csr_wdata;
               CSR_SEMI_SQUAT_LIMIT: semi_lim  = csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) take_leg(req_tlast, req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            g = frame_type'(rsp_tdata[68:0]);
            if (frame_queue.size() == 0) begin
               note_mismatch("unexpected result", 0, 1);
            end else begin
               e = frame_queue.pop_front();
               if (e.left_angle != g.left_angle)
                  note_mismatch("left_angle", e.left_angle, g.left_angle);
               if (e.left_valid != g.left_valid)
                  note_mismatch("left_valid", e.left_valid, g.left_valid);
               if (e.right_angle != g.right_angle)
                  note_mismatch("right_angle", e.right_angle, g.right_angle);
               if (e.right_valid != g.right_valid)
                  note_mismatch("right_valid", e.right_valid, g.right_valid);
               if (e.left_comp != g.left_comp)
                  note_mismatch("left_compression", $signed(e.left_comp), $signed(g.left_comp));
               if (e.right_comp != g.right_comp)
                  note_mismatch("right_compression", $signed(e.right_comp),
                                $signed(g.right_comp));
               if (e.squat_class != g.squat_class)
                  note_mismatch("squat_class", e.squat_class, g.squat_class);
               if (e.symmetry != g.symmetry)
                  note_mismatch("symmetry", e.symmetry, g.symmetry);
               if (e.sym_valid != g.sym_valid)
                  note_mismatch("symmetry_valid", e.sym_valid, g.sym_valid);
            end
         end
      end
   end

   initial mismatches = 0;

endmodule

>>> dv/leg_pose_squat_metrics_tb.sv
// ----------------------------------------------------------------------------
// leg_pose_squat_metrics_tb
// Drives legs, register settings and output back-pressure into the squat
// metrics block; the checker beside it predicts and compares every frame.
// ----------------------------------------------------------------------------
module leg_pose_squat_metrics_tb;
   import lpsm_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint CYCLE_LIMIT = 3000000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [95:0] req_tdata;   // hip_x, hip_y, knee_x, knee_y, ankle_x, ankle_y, three scores
   logic        req_tlast;   // side: set on the right leg, which closes the frame
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [71:0] rsp_tdata;   // left_angle, left_valid, right_angle, right_valid, left and
                             // right compression, squat_class, symmetry, symmetry_valid
   logic        csr_we;
   logic [1:0]  csr_addr;
   logic [12:0] csr_wdata;
   int          mismatches;
   int          frames_pending;
   longint      cycles;
   logic [7:0]  cur_threshold;

   leg_pose_squat_metrics DUT (.*);

   lpsm_tb_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // The run is bounded by a plain cycle count, whatever happens to the handshakes.
   initial cycles = 0;
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Gap lengths: mostly none or short, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // The receiver alternates ready stretches with stalls of random length.
   initial begin
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 40)) @(posedge clock);
         if ($urandom_range(0, 3) != 0) begin
            rsp_tready <= 1'b0;
            repeat (pick_gap() + 1) @(posedge clock);
         end
      end
   end

   function automatic logic [95:0] pack_leg(int hx, int hy, int kx, int ky, int ax, int ay,
                                            int hs, int ks, int as_);
      return {8'(as_), 8'(ks), 8'(hs), 12'(ay), 12'(ax), 12'(ky), 12'(kx), 12'(hy), 12'(hx)};
   endfunction

   // One leg transfer; valid is only lowered when a gap follows.
   task automatic send_leg(input logic side, input logic [95:0] d);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      req_tlast  <= side;
      do @(posedge clock); while (!req_tready);
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // A score that passes the threshold most of the time, otherwise anything.
   function automatic int pick_score();
      if ($urandom_range(0, 99) < 88 && cur_threshold != 8'hFF)
         return $urandom_range(int'(cur_threshold) + 1, 255);
      return $urandom_range(0, 255);
   endfunction

   // Random leg content: now and then a joint sits on the knee or the leg has no height.
   function automatic logic [95:0] random_leg();
      int hx, hy, kx, ky, ax, ay, r;
      hx = $urandom_range(0, 4095); hy = $urandom_range(0, 4095);
      kx = $urandom_range(0, 4095); ky = $urandom_range(0, 4095);
      ax = $urandom_range(0, 4095); ay = $urandom_range(0, 4095);
      r = $urandom_range(0, 99);
      if (r < 4) begin
         kx = hx; ky = hy;
      end else if (r < 8) begin
         ax = kx; ay = ky;
      end else if (r < 12) begin
         ay = hy;
      end else if (r < 40) begin
         // Heights no larger than half the calibrated ones keep the compression out of saturation.
         ay = hy + $urandom_range(0, 2000) - 1000;
         if (ay < 0) ay = 0;
         if (ay > 4095) ay = 4095;
      end
      return pack_leg(hx, hy, kx, ky, ax, ay, pick_score(), pick_score(), pick_score());
   endfunction

   // One register write, after which the write port is left idle before the task returns.
   task automatic write_reg(input logic [1:0] idx, input logic [12:0] val);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
      if (idx == CSR_SCORE_THRESHOLD) cur_threshold = val[7:0];
      @(posedge clock);
   endtask

   // Settles the block: every frame delivered, then time for a lone left leg to finish.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (frames_pending != 0) @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   task automatic random_phase(input int legs);
      int n, r;
      n = 0;
      while (n < legs) begin
         r = $urandom_range(0, 99);
         if (r < 80) begin
            send_leg(1'b0, random_leg());
            send_leg(1'b1, random_leg());
            n += 2;
         end else if (r < 90) begin
            send_leg(1'b1, random_leg());
            n += 1;
         end else begin
            send_leg(1'b0, random_leg());
            n += 1;
         end
      end
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tlast  = 1'b0;
      csr_we     = 1'b0;
      csr_addr   = CSR_SCORE_THRESHOLD;
      csr_wdata  = '0;
      cur_threshold = 8'd128;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed frames. The first straight legs calibrate both standing heights at 2000.
      send_leg(1'b0, pack_leg(100, 100, 100, 1100, 100, 2100, 200, 200, 200));
      send_leg(1'b1, pack_leg(300, 100, 300, 1100, 300, 2100, 255, 255, 255));
      // Knee bent at a right angle and a deeper leg on the other side.
      send_leg(1'b0, pack_leg(1000, 1000, 1000, 2000, 2000, 2000, 129, 129, 129));
      send_leg(1'b1, pack_leg(0, 0, 4095, 4095, 0, 500, 255, 255, 255));
      // Scores equal to the threshold make a leg invalid.
      send_leg(1'b0, pack_leg(100, 100, 200, 900, 120, 1800, 128, 255, 255));
      send_leg(1'b1, pack_leg(100, 100, 200, 900, 120, 1800, 255, 128, 255));
      // Degenerate legs: all coordinates zero, and all at the maximum.
      send_leg(1'b0, pack_leg(0, 0, 0, 0, 0, 0, 255, 255, 255));
      send_leg(1'b1, pack_leg(4095, 4095, 4095, 4095, 4095, 4095, 255, 255, 255));
      // A right leg with no left leg before it.
      send_leg(1'b1, pack_leg(500, 200, 700, 1200, 500, 2200, 200, 200, 200));
      // Two left legs in a row, the second one counts.
      send_leg(1'b0, pack_leg(500, 200, 900, 1000, 500, 1800, 200, 200, 200));
      send_leg(1'b0, pack_leg(500, 200, 600, 1200, 500, 2200, 200, 200, 0));
      send_leg(1'b1, pack_leg(500, 200, 600, 1200, 500, 2200, 200, 200, 200));
      // Ankle above the hip, a strongly negative compression, and zero height.
      send_leg(1'b0, pack_leg(4095, 4095, 0, 2000, 4095, 0, 255, 255, 255));
      send_leg(1'b1, pack_leg(10, 4000, 3000, 3000, 4000, 4000, 255, 255, 255));
      // Hip and ankle on opposite sides, angle close to zero and close to straight.
      send_leg(1'b0, pack_leg(2000, 0, 2000, 2000, 2001, 0, 255, 255, 255));
      send_leg(1'b1, pack_leg(0, 0, 2048, 2048, 4095, 4094, 255, 255, 255));
      drain();

      random_phase(250);
      drain();
      write_reg(CSR_SCORE_THRESHOLD, 13'd0);
      write_reg(CSR_STANDING_LIMIT, 13'd0);
      write_reg(CSR_SEMI_SQUAT_LIMIT, 13'd4096);
      random_phase(250);
      drain();
      write_reg(CSR_SCORE_THRESHOLD, 13'd255);
      write_reg(CSR_STANDING_LIMIT, 13'd4096);
      write_reg(CSR_SEMI_SQUAT_LIMIT, 13'd0);
      random_phase(60);
      drain();
      write_reg(CSR_SCORE_THRESHOLD, 13'd170);
      write_reg(CSR_STANDING_LIMIT, 13'd4096);
      write_reg(CSR_SEMI_SQUAT_LIMIT, 13'd4096);
      random_phase(250);
      drain();
      write_reg(CSR_SCORE_THRESHOLD, 13'd85);
      write_reg(CSR_STANDING_LIMIT, 13'd0);
      write_reg(CSR_SEMI_SQUAT_LIMIT, 13'd0);
      random_phase(250);
      drain();
      write_reg(CSR_SCORE_THRESHOLD, 13'd30);
      write_reg(CSR_STANDING_LIMIT, 13'(int'($urandom_range(0, 2047))));
      write_reg(CSR_SEMI_SQUAT_LIMIT, 13'(int'($urandom_range(2048, 4096))));
      random_phase(280);
      drain();

      if (mismatches == 0 && frames_pending == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
